// ----- rtl/core/scf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    localparam int MAX_STRIPS_DEF    = 10;
    localparam int SENSOR_STRIPS_DEF = 1024;

    localparam int RAW_W    = 16;
    localparam int LAYER_W  = 2;
    localparam int CHARGE_W = 8;
    localparam int STRIP_W  = 10;
    localparam int COUNT_W  = 4;

    localparam logic [CHARGE_W-1:0] CHARGE_CAP = 8'hFF;

    // Output stream packing, lowest bits first.
    localparam int OUT_DATA_BITS = 2 * STRIP_W + 2 * COUNT_W + CHARGE_W;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [RAW_W-1:0]   raw_charge;
        logic [LAYER_W-1:0] layer_id;
        logic               sensor_last;
    } t_strip;

    typedef struct packed {
        logic [LAYER_W-1:0]  cluster_layer;
        logic [STRIP_W-1:0]  first_strip;
        logic [COUNT_W-1:0]  strip_count;
        logic [COUNT_W-1:0]  peak_offset;
        logic [CHARGE_W-1:0] peak_charge;
        logic [STRIP_W-1:0]  hit_strip;
    } t_cluster;

endpackage

`default_nettype wire

// ----- rtl/core/strip_cluster_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata                    tuser          tlast
// s_axis    in         raw_charge               layer_id       sensor_last
// m_axis    out        cluster fields (40 bits) cluster_layer  -
//
// One strip is taken every cycle unless a stall on m_axis backs up into the input
// register. The cluster that a strip closes passes through the input register, then
// the result register, before it is offered on m_axis.
// The cluster update itself is a single compare-and-add on the registered strip.
// Reset clears the open cluster and sets the strip position to zero.
// A stall on m_axis holds the result; s_axis keeps taking strips while the
// input register can move forward.

module strip_cluster_finder #(
    parameter int MAX_STRIPS    = scf_pkg::MAX_STRIPS_DEF,
    parameter int SENSOR_STRIPS = scf_pkg::SENSOR_STRIPS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [scf_pkg::RAW_W-1:0]        s_axis_tdata,   // [15:0] raw_charge
    input  wire  [scf_pkg::LAYER_W-1:0]      s_axis_tuser,   // [1:0] layer_id
    input  wire                              s_axis_tlast,   // sensor_last
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [9:0] first_strip, [13:10] strip_count, [17:14] peak_offset,
    // [25:18] peak_charge, [35:26] hit_strip, [39:36] zero
    output logic [scf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [scf_pkg::LAYER_W-1:0]      m_axis_tuser    // [1:0] cluster_layer
);

    logic              r_in_valid;
    scf_pkg::t_strip   r_in_strip;
    logic              r_out_valid;
    scf_pkg::t_cluster r_out;

    logic              out_free;
    logic              process;
    logic              emit;
    scf_pkg::t_cluster cluster;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_strip.raw_charge  <= s_axis_tdata;
            r_in_strip.layer_id    <= s_axis_tuser;
            r_in_strip.sensor_last <= s_axis_tlast;
        end
    end

    scf_cluster #(
        .MAX_STRIPS    (MAX_STRIPS),
        .SENSOR_STRIPS (SENSOR_STRIPS)
    ) u_cluster (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (process),
        .i_strip   (r_in_strip),
        .o_emit    (emit),
        .o_cluster (cluster)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= process && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && emit) begin
            r_out <= cluster;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.cluster_layer;
    assign m_axis_tdata  = {
        {(scf_pkg::OUT_DATA_W - scf_pkg::OUT_DATA_BITS){1'b0}},
        r_out.hit_strip,
        r_out.peak_charge,
        r_out.peak_offset,
        r_out.strip_count,
        r_out.first_strip
    };

endmodule

`default_nettype wire

// ----- rtl/core/scf_cluster.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scf_cluster #(
    parameter int MAX_STRIPS    = scf_pkg::MAX_STRIPS_DEF,
    parameter int SENSOR_STRIPS = scf_pkg::SENSOR_STRIPS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire scf_pkg::t_strip  i_strip,
    output logic                  o_emit,
    output scf_pkg::t_cluster     o_cluster
);

    localparam int LEN_W = $clog2(MAX_STRIPS + 1);
    localparam int POS_W = $clog2(SENSOR_STRIPS);
    localparam int SUM_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    logic                         r_in_cluster, n_in_cluster;
    logic [LEN_W-1:0]             r_run_length, n_run_length;
    logic [POS_W-1:0]             r_run_start, n_run_start;
    logic [scf_pkg::CHARGE_W-1:0] r_best_charge, n_best_charge;
    logic [LEN_W-1:0]             r_best_offset, n_best_offset;
    logic [POS_W-1:0]             r_position, n_position;
    logic [scf_pkg::LAYER_W-1:0]  r_run_layer, n_run_layer;

    logic [scf_pkg::CHARGE_W-1:0] charge;
    logic [SUM_W-1:0]             hit_sum;

    always_comb begin
        if (|i_strip.raw_charge[scf_pkg::RAW_W-1:scf_pkg::CHARGE_W]) begin
            charge = scf_pkg::CHARGE_CAP;
        end else begin
            charge = i_strip.raw_charge[scf_pkg::CHARGE_W-1:0];
        end
    end

    always_comb begin
        n_in_cluster  = r_in_cluster;
        n_run_length  = r_run_length;
        n_run_start   = r_run_start;
        n_best_charge = r_best_charge;
        n_best_offset = r_best_offset;
        n_run_layer   = r_run_layer;
        o_emit        = 1'b0;

        if (r_in_cluster) begin
            if (charge == '0) begin
                o_emit       = 1'b1;
                n_in_cluster = 1'b0;
            end else begin
                if (charge > r_best_charge) begin
                    n_best_charge = charge;
                    n_best_offset = r_run_length;
                end
                n_run_length = r_run_length + LEN_W'(1);
                if (n_run_length >= LEN_W'(MAX_STRIPS) || i_strip.sensor_last) begin
                    o_emit       = 1'b1;
                    n_in_cluster = 1'b0;
                end
            end
        end else if (charge != '0) begin
            n_in_cluster  = 1'b1;
            n_run_start   = r_position;
            n_run_length  = LEN_W'(1);
            n_best_charge = charge;
            n_best_offset = '0;
            n_run_layer   = i_strip.layer_id;
            if (n_run_length >= LEN_W'(MAX_STRIPS) || i_strip.sensor_last) begin
                o_emit       = 1'b1;
                n_in_cluster = 1'b0;
            end
        end

        if (i_strip.sensor_last || r_position == POS_W'(SENSOR_STRIPS - 1)) begin
            n_position = '0;
        end else begin
            n_position = r_position + POS_W'(1);
        end
    end

    assign hit_sum = SUM_W'(n_run_start) + SUM_W'(n_best_offset);

    always_comb begin
        o_cluster.cluster_layer = n_run_layer;
        o_cluster.first_strip   = scf_pkg::STRIP_W'(n_run_start);
        o_cluster.strip_count   = scf_pkg::COUNT_W'(n_run_length);
        o_cluster.peak_offset   = scf_pkg::COUNT_W'(n_best_offset);
        o_cluster.peak_charge   = n_best_charge;
        o_cluster.hit_strip     = scf_pkg::STRIP_W'(hit_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cluster  <= 1'b0;
            r_run_length  <= '0;
            r_run_start   <= '0;
            r_best_charge <= '0;
            r_best_offset <= '0;
            r_position    <= '0;
            r_run_layer   <= '0;
        end else if (i_valid) begin
            r_in_cluster  <= n_in_cluster;
            r_run_length  <= n_run_length;
            r_run_start   <= n_run_start;
            r_best_charge <= n_best_charge;
            r_best_offset <= n_best_offset;
            r_position    <= n_position;
            r_run_layer   <= n_run_layer;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    typedef scf_pkg::t_strip   t_strip;
    typedef scf_pkg::t_cluster t_cluster;

    localparam int RAW_W      = scf_pkg::RAW_W;
    localparam int LAYER_W    = scf_pkg::LAYER_W;
    localparam int CHARGE_W   = scf_pkg::CHARGE_W;
    localparam int STRIP_W    = scf_pkg::STRIP_W;
    localparam int COUNT_W    = scf_pkg::COUNT_W;
    localparam int OUT_DATA_W = scf_pkg::OUT_DATA_W;
    localparam logic [CHARGE_W-1:0] CHARGE_CAP = scf_pkg::CHARGE_CAP;

    localparam int MAX_STRIPS    = scf_pkg::MAX_STRIPS_DEF;
    localparam int SENSOR_STRIPS = scf_pkg::SENSOR_STRIPS_DEF;
    localparam int RANDOM_ITEMS  = 1880;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int POS_W         = 13;

    typedef struct {
        t_strip   strip;
        bit       typed;
        t_cluster want;
    } t_strip_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [RAW_W-1:0]      s_axis_tdata = '0;
    logic [LAYER_W-1:0]    s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [LAYER_W-1:0]    m_axis_tuser;

    t_cluster   cluster_q[$];
    t_strip_row strip_rows[$];
    int         fail_count = 0;
    int         idle_cycles = 0;

    // Shadow of the cluster state, updated once per accepted strip.
    bit                  run_open = 1'b0;
    logic [COUNT_W:0]    run_len = '0;
    logic [POS_W-1:0]    run_first = '0;
    logic [CHARGE_W-1:0] peak_q = '0;
    logic [COUNT_W-1:0]  peak_at = '0;
    logic [LAYER_W-1:0]  run_layer = '0;
    logic [POS_W-1:0]    strip_pos = '0;

    bit rdy_state = 1'b0;
    int rdy_left = 0;

    strip_cluster_finder #(
        .MAX_STRIPS   (MAX_STRIPS),
        .SENSOR_STRIPS(SENSOR_STRIPS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [15:0] raw_charge
        .s_axis_tuser (s_axis_tuser),   // [1:0] layer_id
        .s_axis_tlast (s_axis_tlast),   // sensor_last
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // first_strip, strip_count, peak_offset,
                                        // peak_charge, hit_strip, zero fill
        .m_axis_tuser (m_axis_tuser)    // [1:0] cluster_layer
    );

    always #1 i_clk = ~i_clk;

    function automatic bit predict_cluster(input t_strip s, output t_cluster c);
        logic [CHARGE_W-1:0] q;
        bit done;
        q = (s.raw_charge > RAW_W'(CHARGE_CAP)) ? CHARGE_CAP : s.raw_charge[CHARGE_W-1:0];
        done = 1'b0;
        c = '0;
        if (run_open) begin
            if (q == '0) begin
                done = 1'b1;
            end else begin
                if (q > peak_q) begin
                    peak_q = q;
                    peak_at = run_len[COUNT_W-1:0];
                end
                run_len = run_len + 1'b1;
                done = (run_len >= MAX_STRIPS) || s.sensor_last;
            end
        end else if (q != '0) begin
            run_open = 1'b1;
            run_first = strip_pos;
            run_len = {{COUNT_W{1'b0}}, 1'b1};
            peak_q = q;
            peak_at = '0;
            run_layer = s.layer_id;
            done = (run_len >= MAX_STRIPS) || s.sensor_last;
        end
        if (done) begin
            c.cluster_layer = run_layer;
            c.first_strip = run_first[STRIP_W-1:0];
            c.strip_count = run_len[COUNT_W-1:0];
            c.peak_offset = peak_at;
            c.peak_charge = peak_q;
            c.hit_strip = STRIP_W'(run_first + peak_at);
            run_open = 1'b0;
        end
        if (s.sensor_last || (strip_pos + 1 >= SENSOR_STRIPS)) begin
            strip_pos = '0;
        end else begin
            strip_pos = strip_pos + 1'b1;
        end
        return done;
    endfunction

    function automatic t_strip_row strip_row(input int raw, input int layer, input bit last,
                                             input bit typed = 1'b0, input int c_layer = 0,
                                             input int first = 0, input int count = 0,
                                             input int offset = 0, input int peak = 0,
                                             input int hit = 0);
        t_strip_row r;
        r.strip.raw_charge = RAW_W'(raw);
        r.strip.layer_id = LAYER_W'(layer);
        r.strip.sensor_last = last;
        r.typed = typed;
        r.want.cluster_layer = LAYER_W'(c_layer);
        r.want.first_strip = STRIP_W'(first);
        r.want.strip_count = COUNT_W'(count);
        r.want.peak_offset = COUNT_W'(offset);
        r.want.peak_charge = CHARGE_W'(peak);
        r.want.hit_strip = STRIP_W'(hit);
        return r;
    endfunction

    function automatic void add_row(input t_strip_row r);
        strip_rows.insert(strip_rows.size(), r);
    endfunction

    function automatic logic [RAW_W-1:0] random_charge(input int zero_pct);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < zero_pct) begin
            return '0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return RAW_W'($urandom_range(1, 255));
        end else if (pick < 85) begin
            return RAW_W'($urandom_range(256, 65535));
        end else if (pick < 92) begin
            return RAW_W'($urandom_range(254, 256));
        end
        return {RAW_W{1'b1}};
    endfunction

    function automatic string cluster_text(input t_cluster c);
        return $sformatf("layer=%0d first=%0d count=%0d off=%0d peak=%0d hit=%0d",
                         c.cluster_layer, c.first_strip, c.strip_count,
                         c.peak_offset, c.peak_charge, c.hit_strip);
    endfunction

    task automatic send_strip(input t_strip s, input bit burst, input bit typed,
                              input t_cluster typed_want);
        t_cluster c;
        int gap;
        int unsigned pick;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s.raw_charge;
        s_axis_tuser <= s.layer_id;
        s_axis_tlast <= s.sensor_last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (predict_cluster(s, c) || typed) begin
            cluster_q.insert(cluster_q.size(), typed ? typed_want : c);
        end
        gap = 0;
        if (!burst) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92) begin
                gap = $urandom_range(8, 30);
            end else if (pick >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_clusters();
        s_axis_tvalid <= 1'b0;
        while (cluster_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_cluster(input t_cluster got);
        t_cluster want;
        if (cluster_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("unexpected cluster: %s", cluster_text(got));
            end
        end else begin
            want = cluster_q.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("cluster mismatch: expected %s", cluster_text(want));
                    $display("                  got      %s", cluster_text(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_cluster got;
        int unsigned pick;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.cluster_layer = m_axis_tuser;
                got.first_strip = m_axis_tdata[STRIP_W-1:0];
                got.strip_count = m_axis_tdata[STRIP_W +: COUNT_W];
                got.peak_offset = m_axis_tdata[STRIP_W+COUNT_W +: COUNT_W];
                got.peak_charge = m_axis_tdata[STRIP_W+2*COUNT_W +: CHARGE_W];
                got.hit_strip = m_axis_tdata[STRIP_W+2*COUNT_W+CHARGE_W +: STRIP_W];
                check_cluster(got);
            end
            if (rdy_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    rdy_state = 1'b1;
                    rdy_left = $urandom_range(100, 300);
                end else if (pick < 50) begin
                    rdy_state = 1'b1;
                    rdy_left = $urandom_range(1, 40);
                end else if (pick < 92) begin
                    rdy_state = 1'b0;
                    rdy_left = $urandom_range(1, 3);
                end else begin
                    rdy_state = 1'b0;
                    rdy_left = $urandom_range(10, 30);
                end
            end else begin
                rdy_left--;
            end
            m_axis_tready <= rdy_state;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_strip s;
        t_cluster none;
        int sent;
        int len;
        int zero_pct;
        bit burst;
        bit long_done;
        bit close_sensor;
        logic [LAYER_W-1:0] layer;

        none = '0;
        // Saturation, sensor end, a zero strip marked last, a layer change inside a
        // cluster, a full-length cluster and the strip right after it.
        add_row(strip_row(16'hFFFF, 3, 1, 1, 3, 0, 1, 0, 255, 0));
        add_row(strip_row(16'h0000, 0, 0));
        add_row(strip_row(16'h0001, 0, 0));
        add_row(strip_row(16'h0100, 2, 0));
        add_row(strip_row(16'h0000, 1, 1, 1, 0, 1, 2, 1, 255, 2));
        add_row(strip_row(200, 1, 0));
        add_row(strip_row(200, 0, 0));
        add_row(strip_row(200, 3, 0));
        add_row(strip_row(16'h8000, 2, 0));
        add_row(strip_row(200, 0, 0));
        add_row(strip_row(200, 0, 0));
        add_row(strip_row(200, 0, 0));
        add_row(strip_row(200, 0, 0));
        add_row(strip_row(200, 0, 0));
        add_row(strip_row(200, 0, 0, 1, 1, 0, 10, 3, 255, 3));
        add_row(strip_row(16'h7FFF, 2, 0));
        add_row(strip_row(16'h00FF, 1, 1, 1, 2, 10, 2, 0, 255, 10));
        add_row(strip_row(16'h0000, 3, 1));
        add_row(strip_row(16'h0001, 1, 0));
        add_row(strip_row(16'hAAAA, 1, 0));
        add_row(strip_row(16'h5555, 2, 0));
        add_row(strip_row(16'h00FE, 0, 0));
        add_row(strip_row(16'h0000, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (strip_rows[i]) begin
            send_strip(strip_rows[i].strip, 1'b0, strip_rows[i].typed, strip_rows[i].want);
        end
        wait_for_clusters();

        // Sensors of random length; one runs past SENSOR_STRIPS so the position wraps.
        sent = 0;
        long_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (!long_done && sent > 400) begin
                long_done = 1'b1;
                len = SENSOR_STRIPS + 20;
                zero_pct = 20;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: zero_pct = 3;
                    1: zero_pct = 20;
                    2: zero_pct = 40;
                    default: zero_pct = 75;
                endcase
            end
            layer = LAYER_W'($urandom_range(0, 3));
            burst = ($urandom_range(0, 3) == 0);
            close_sensor = ($urandom_range(0, 9) != 0) || (len > SENSOR_STRIPS);
            for (int k = 0; k < len; k++) begin
                s.raw_charge = random_charge(zero_pct);
                s.layer_id = ($urandom_range(0, 9) == 0) ? LAYER_W'($urandom_range(0, 3)) : layer;
                if (k == len - 1) begin
                    s.sensor_last = close_sensor;
                end else begin
                    s.sensor_last = (len <= SENSOR_STRIPS) && ($urandom_range(0, 49) == 0);
                end
                send_strip(s, burst, 1'b0, none);
            end
            sent += len;
            if ($urandom_range(0, 19) == 0) begin
                wait_for_clusters();
            end
        end

        wait_for_clusters();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
